@@ design/egos_pkg.sv @@
// shared constants, types and pixel similarity function for the overlap scorer
`timescale 1ns / 1ps
package egos_pkg;

  localparam int unsigned PIXEL_WIDTH = 32;
  localparam int unsigned RGB_WIDTH = 24;
  localparam int unsigned SIM_WIDTH = 10;
  localparam int unsigned THRESH_WIDTH = 10;
  localparam int unsigned SCORE_WIDTH = 40;
  localparam int unsigned OUT_WIDTH = 40;
  localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = THRESH_WIDTH'((255 - 32) * 3);
  localparam logic [7:0] BYTE_MAX = 8'hff;

  typedef logic [RGB_WIDTH-1:0] rgb_t;
  typedef logic [SIM_WIDTH-1:0] sim_t;
  typedef logic [SCORE_WIDTH-1:0] score_t;

  // 255 minus absolute difference, summed over r, g and b
  function automatic sim_t pix_sim(input rgb_t a, input rgb_t b);
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] d;
    sim_t acc;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      x = a[8*i +: 8];
      y = b[8*i +: 8];
      d = (x > y) ? (x - y) : (y - x);
      acc = acc + SIM_WIDTH'(BYTE_MAX - d);
    end
    return acc;
  endfunction

endpackage

@@ design/egos_in_if.sv @@
// pixel pair channel interface
`timescale 1ns / 1ps
interface egos_in_if
  import egos_pkg::*;
();
  logic valid;
  logic ready;
  logic [PIXEL_WIDTH-1:0] source_pixel;
  logic [PIXEL_WIDTH-1:0] target_pixel;
  logic row_first;
  logic frame_last;

  modport source (output valid, source_pixel, target_pixel, row_first, frame_last,
                  input ready);
  modport sink (input valid, source_pixel, target_pixel, row_first, frame_last,
                output ready);
endinterface

@@ design/egos_out_if.sv @@
// score result channel interface
`timescale 1ns / 1ps
interface egos_out_if
  import egos_pkg::*;
();
  logic valid;
  logic ready;
  logic [OUT_WIDTH-1:0] overlap_score;

  modport source (output valid, overlap_score, input ready);
  modport sink (input valid, overlap_score, output ready);
endinterface

@@ design/edge_gated_overlap_score_core.sv @@
// edge-gated overlap similarity scorer, top level
//
// Pixel pairs of an overlap region enter one word per clock in raster order on
// pix_in; a pair adds the rgb similarity of its two pixels to a saturating score
// only where both pixels differ enough from their left neighbours (neighbour
// similarity below edge_threshold). The word marked frame_last closes the
// region: the score including that pair leaves on score_out and the sum
// restarts at zero. Throughput is one pair per clock; a pair is held in the
// input register, where similarity, edge test and accumulate are done, and its
// score appears in the output register the cycle after it leaves. The input
// stalls only when a finished score waits in the output register and another
// frame_last word reaches the accumulate stage. edge_threshold resets to 669;
// the user must write it with cfg_we only while the block is idle (unchecked).
`timescale 1ns / 1ps
module edge_gated_overlap_score_core
  import egos_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [THRESH_WIDTH-1:0] cfg_wdata,
  egos_in_if.sink                 pix_in,
  egos_out_if.source              score_out
);

  logic [THRESH_WIDTH-1:0] edge_threshold;

  logic   s1_valid;
  rgb_t   s1_src;
  rgb_t   s1_tgt;
  logic   s1_first;
  logic   s1_last;
  rgb_t   prev_src;
  rgb_t   prev_tgt;
  score_t score_sum;
  score_t score_sum_next;
  score_t score_acc;

  logic   s1_fire;
  rgb_t   nb_src;
  rgb_t   nb_tgt;
  logic   both_edge;
  sim_t   pair_sim;
  logic [SCORE_WIDTH:0] sum_wide;

  logic                 out_valid;
  logic [OUT_WIDTH-1:0] out_score;

  assign s1_fire = s1_valid && (!s1_last || !out_valid || score_out.ready);
  assign pix_in.ready = !s1_valid || s1_fire;

  // left neighbour is the pixel itself at a row start
  assign nb_src = s1_first ? s1_src : prev_src;
  assign nb_tgt = s1_first ? s1_tgt : prev_tgt;
  assign both_edge = (pix_sim(nb_src, s1_src) < SIM_WIDTH'(edge_threshold))
                  && (pix_sim(nb_tgt, s1_tgt) < SIM_WIDTH'(edge_threshold))
                  && ({1'b0, pix_sim(nb_src, s1_src)} < {1'b0, edge_threshold});
  assign pair_sim = pix_sim(s1_src, s1_tgt);

  always_comb begin
    sum_wide = {1'b0, score_sum} + (SCORE_WIDTH + 1)'(pair_sim);
    if (!both_edge) begin
      score_acc = score_sum;
    end else if (sum_wide[SCORE_WIDTH]) begin
      score_acc = '1;
    end else begin
      score_acc = sum_wide[SCORE_WIDTH-1:0];
    end
    score_sum_next = s1_last ? '0 : score_acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_threshold <= THRESH_RESET;
      s1_valid <= 1'b0;
      prev_src <= '0;
      prev_tgt <= '0;
      score_sum <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        edge_threshold <= cfg_wdata;
      end
      if (pix_in.ready) begin
        s1_valid <= pix_in.valid;
      end
      if (s1_fire) begin
        prev_src <= s1_src;
        prev_tgt <= s1_tgt;
        score_sum <= score_sum_next;
      end
      if (s1_fire && s1_last) begin
        out_valid <= 1'b1;
      end else if (score_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pix_in.valid && pix_in.ready) begin
      s1_src <= pix_in.source_pixel[RGB_WIDTH-1:0];
      s1_tgt <= pix_in.target_pixel[RGB_WIDTH-1:0];
      s1_first <= pix_in.row_first;
      s1_last <= pix_in.frame_last;
    end
    if (s1_fire && s1_last) begin
      out_score <= OUT_WIDTH'(score_acc);
    end
  end

  assign score_out.valid = out_valid;
  assign score_out.overlap_score = out_score;

  a_last_gives_word: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_last |=> score_out.valid)
    else $error("frame end did not produce a score word");

  a_sum_clears: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_last |=> score_sum == '0)
    else $error("score not cleared after frame end");

  a_sum_monotonic: assert property (@(posedge clk) disable iff (rst)
    s1_fire && !s1_last |=> score_sum >= $past(score_sum))
    else $error("score decreased within a frame");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !score_out.valid |-> pix_in.ready)
    else $error("input stalled with empty output register");

endmodule

@@ tb/edge_gated_overlap_score_core_test.sv @@
// testbench for the edge-gated overlap scorer: directed rows, random frames, scoreboard
`timescale 1ns / 1ps
module edge_gated_overlap_score_core_test;
  import egos_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam score_t SCORE_CAP = '1;

  typedef struct packed {
    logic [PIXEL_WIDTH-1:0] source_pixel;
    logic [PIXEL_WIDTH-1:0] target_pixel;
    logic row_first;
    logic frame_last;
  } pixel_pair_t;

  typedef struct packed {
    logic [PIXEL_WIDTH-1:0] source_pixel;
    logic [PIXEL_WIDTH-1:0] target_pixel;
    logic row_first;
    logic frame_last;
    logic typed;
    score_t score;
  } probe_row_t;

  localparam int unsigned PROBE_COUNT = 14;
  localparam probe_row_t PROBE_ROWS [PROBE_COUNT] = '{
    '{32'hffffffff, 32'hffffffff, 1'b0, 1'b1, 1'b1, 40'd765},
    '{32'h00000000, 32'h00000000, 1'b1, 1'b1, 1'b1, 40'd0},
    '{32'hff000000, 32'h00000000, 1'b0, 1'b0, 1'b0, 40'd0},
    '{32'h12ffffff, 32'habffffff, 1'b0, 1'b1, 1'b1, 40'd765},
    '{32'h00ff00ff, 32'h0000ff00, 1'b1, 1'b0, 1'b0, 40'd0},
    '{32'h0000ff00, 32'h00ff00ff, 1'b0, 1'b1, 1'b1, 40'd0},
    '{32'h00102030, 32'h00112233, 1'b1, 1'b0, 1'b0, 40'd0},
    '{32'h00f0e0d0, 32'h00f1e2d3, 1'b0, 1'b0, 1'b0, 40'd0},
    '{32'h00808080, 32'h00707070, 1'b0, 1'b0, 1'b0, 40'd0},
    '{32'h80000000, 32'h80ffffff, 1'b1, 1'b0, 1'b0, 40'd0},
    '{32'h7f7f7f7f, 32'h00000000, 1'b0, 1'b1, 1'b0, 40'd0},
    '{32'h00123456, 32'h00654321, 1'b1, 1'b1, 1'b1, 40'd0},
    '{32'h00ffffff, 32'h00ffffff, 1'b0, 1'b0, 1'b0, 40'd0},
    '{32'h00000000, 32'h00000000, 1'b0, 1'b1, 1'b0, 40'd0}
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [THRESH_WIDTH-1:0] cfg_wdata;

  egos_in_if pix_if ();
  egos_out_if score_if ();

  edge_gated_overlap_score_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pix_in    (pix_if),
    .score_out (score_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [THRESH_WIDTH-1:0] edge_thresh;
  rgb_t last_src;
  rgb_t last_tgt;
  score_t running_score;
  score_t frame_scores[$];
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;

  function automatic logic [9:0] rgb_likeness(input rgb_t a, input rgb_t b);
    logic [9:0] total;
    logic [7:0] x;
    logic [7:0] y;
    total = '0;
    for (int k = 0; k < 3; k++) begin
      x = a[8*k +: 8];
      y = b[8*k +: 8];
      total = total + 10'(8'hff - ((x > y) ? (x - y) : (y - x)));
    end
    return total;
  endfunction

  function automatic bit score_pair(input pixel_pair_t p, output score_t frame_score);
    rgb_t src;
    rgb_t tgt;
    rgb_t left_src;
    rgb_t left_tgt;
    logic [9:0] gain;
    src = p.source_pixel[RGB_WIDTH-1:0];
    tgt = p.target_pixel[RGB_WIDTH-1:0];
    left_src = p.row_first ? src : last_src;
    left_tgt = p.row_first ? tgt : last_tgt;
    if (rgb_likeness(left_src, src) < edge_thresh && rgb_likeness(left_tgt, tgt) < edge_thresh)
    begin
      gain = rgb_likeness(src, tgt);
      if (running_score > SCORE_CAP - score_t'(gain)) running_score = SCORE_CAP;
      else running_score = running_score + score_t'(gain);
    end
    last_src = src;
    last_tgt = tgt;
    frame_score = running_score;
    if (p.frame_last) begin
      running_score = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [31:0] extreme_pixel();
    logic [31:0] v;
    for (int k = 0; k < 4; k++) v[8*k +: 8] = $urandom_range(1) ? 8'hff : 8'h00;
    return v;
  endfunction

  task automatic offer_pair(input pixel_pair_t p, input bit typed, input score_t typed_score);
    score_t predicted;
    while (gaps_on && $urandom_range(99) < 33) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.source_pixel <= p.source_pixel;
    pix_if.target_pixel <= p.target_pixel;
    pix_if.row_first <= p.row_first;
    pix_if.frame_last <= p.frame_last;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    if (score_pair(p, predicted)) frame_scores.push_back(typed ? typed_score : predicted);
  endtask

  task automatic set_threshold(input logic [THRESH_WIDTH-1:0] value);
    pix_if.valid <= 1'b0;
    while (frame_scores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    edge_thresh = value;
  endtask

  task automatic stream_frames(input int unsigned quota);
    int unsigned sent;
    int unsigned cols;
    int unsigned rows;
    int unsigned style;
    pixel_pair_t p;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(9) == 0) begin
        // stray word with random flags
        p.source_pixel = $urandom;
        p.target_pixel = $urandom;
        p.row_first = 1'($urandom_range(1));
        p.frame_last = 1'($urandom_range(1));
        offer_pair(p, 1'b0, '0);
        sent++;
      end else begin
        cols = $urandom_range(1, 6);
        rows = $urandom_range(1, 4);
        if ($urandom_range(15) == 0) cols = $urandom_range(20, 40);
        style = $urandom_range(2);
        for (int r = 0; r < rows; r++) begin
          for (int c = 0; c < cols; c++) begin
            case (style)
              0: begin
                p.source_pixel = $urandom;
                p.target_pixel = $urandom;
              end
              1: begin
                p.source_pixel = extreme_pixel();
                p.target_pixel = ($urandom_range(3) == 0) ? extreme_pixel()
                                 : p.source_pixel ^ ($urandom & 32'hff000000);
              end
              default: begin
                p.source_pixel = $urandom;
                p.target_pixel = p.source_pixel ^ ($urandom & 32'hff0f0f0f);
              end
            endcase
            // occasionally a broken row marker
            p.row_first = (c == 0) ^ ($urandom_range(19) == 0);
            p.frame_last = (r == rows - 1) && (c == cols - 1);
            offer_pair(p, 1'b0, '0);
            sent++;
          end
        end
      end
    end
  endtask

  // result side: ready with random gaps and one long hold-off
  initial begin
    score_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        score_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req <= 1'b0;
      end else begin
        score_if.ready <= !gaps_on || ($urandom_range(99) >= 33);
      end
    end
  end

  always @(posedge clk) begin
    score_t want;
    if (!rst && score_if.valid && score_if.ready) begin
      if (frame_scores.size() == 0) begin
        errors++;
        $error("overlap_score: expected none, got %0d", score_if.overlap_score);
      end else begin
        want = frame_scores.pop_front();
        if (score_if.overlap_score !== want) begin
          errors++;
          $error("overlap_score: expected %0d, got %0d", want, score_if.overlap_score);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((pix_if.valid && pix_if.ready) || (score_if.valid && score_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    pix_if.valid <= 1'b0;
    pix_if.source_pixel <= '0;
    pix_if.target_pixel <= '0;
    pix_if.row_first <= 1'b0;
    pix_if.frame_last <= 1'b0;
    edge_thresh = THRESH_RESET;
    last_src = '0;
    last_tgt = '0;
    running_score = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows at the reset threshold
    for (int i = 0; i < PROBE_COUNT; i++) begin
      offer_pair({PROBE_ROWS[i].source_pixel, PROBE_ROWS[i].target_pixel,
                  PROBE_ROWS[i].row_first, PROBE_ROWS[i].frame_last},
                 PROBE_ROWS[i].typed, PROBE_ROWS[i].score);
    end

    set_threshold(10'd0);
    stream_frames(60);

    gaps_on <= 1'b0;
    set_threshold(10'd765);
    stream_frames(80);
    gaps_on <= 1'b1;

    set_threshold(THRESH_WIDTH'($urandom_range(1, 764)));
    hold_req <= 1'b1;
    stream_frames(80);

    set_threshold(THRESH_RESET);
    stream_frames(80);

    set_threshold(10'd1);
    stream_frames(40);

    set_threshold(THRESH_WIDTH'($urandom_range(300, 700)));
    stream_frames(100);

    pix_if.valid <= 1'b0;
    while (frame_scores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
